// ----- rtl/cpu_instruction_step_core_assert.svh -----
// Assertion macros shared by the instruction step core.
`ifndef CPU_INSTRUCTION_STEP_CORE_ASSERT_SVH
`define CPU_INSTRUCTION_STEP_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define CIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cis_pkg.sv -----
// Shared types, constants and the opcode decoder of the instruction step core.
`timescale 1ns / 1ps
package cis_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        OP_WRITE, OP_READ, OP_EXEC, OP_RESET, OP_IRQ, OP_NMI
    } t_op;

    // Status flag bit positions
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_U = 5;
    localparam int FL_V = 6;
    localparam int FL_N = 7;

    localparam logic [15:0] VEC_IRQ    = 16'hFFFE;
    localparam logic [15:0] VEC_NMI    = 16'hFFFA;
    localparam logic [15:0] VEC_RST    = 16'hFFFC;
    localparam logic [7:0]  STACK_PAGE = 8'h01;
    localparam logic [7:0]  SP_RESET   = 8'hFD;

    typedef enum logic [5:0] {
        K_NONE, K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_TAX, K_TAY,
        K_TSX, K_TXA, K_TXS, K_TYA, K_PHA, K_PHP, K_PLA, K_PLP, K_DEC,
        K_DEX, K_DEY, K_INC, K_INX, K_INY, K_ADC, K_SBC, K_AND, K_EOR,
        K_ORA, K_ASL, K_ASLA, K_LSR, K_LSRA, K_ROL, K_ROLA, K_ROR, K_RORA,
        K_CLC, K_CLD, K_CLI, K_CLV, K_SEC, K_SED, K_SEI, K_CMP, K_CPX,
        K_CPY, K_BIT, K_BCC, K_BCS, K_BEQ, K_BMI, K_BNE, K_BPL, K_BVC,
        K_BVS, K_JMP, K_JSR, K_RTS, K_RTI, K_BRK, K_NOP
    } t_kind;

    typedef enum logic [3:0] {
        M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
        M_IND, M_IZX, M_IZY, M_REL
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        t_mode      mode;
        logic [2:0] cyc;
    } t_dec;

    // Controller states
    typedef enum logic [5:0] {
        S_IDLE, S_MWR, S_MRD, S_MRD2, S_VRD, S_VLO, S_VPC,
        S_INT0, S_INT1, S_INT2, S_FETCH, S_IR, S_ADDR, S_A1, S_A2,
        S_PTR0, S_PTR1, S_PTR2, S_IND0, S_IND1, S_IND2, S_RDOP, S_OPND,
        S_EXEC, S_PULL1, S_PULL2, S_RR, S_RI2, S_RT2, S_RT3, S_JS2, S_DONE
    } t_state;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        U_NOP, U_LATCH, U_MWR, U_MRD, U_RD_LATCH, U_RDEA, U_VLO, U_VEC_PC,
        U_RESET_PC, U_PUSH_PCH, U_PUSH_PCL, U_PUSH_P, U_FETCH, U_IR, U_HALT,
        U_ADDR, U_A1, U_A2, U_TMP_ZPINC, U_TMP_PGINC, U_EA_PTR, U_OPND,
        U_EXEC, U_PULL_RD, U_PULL_LATCH, U_RR, U_RI2, U_RT2, U_RT3, U_JS2
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic brk;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        t_mode mode;
        logic  flag_i;
        logic  running;
    } t_stat;

    // Opcode decoder: kind, addressing mode and base cycle count
    function automatic t_dec cis_decode(input logic [7:0] opc);
        t_dec d;
        d = '{K_NONE, M_IMP, 3'd0};
        unique case (opc)
            8'hA9: d = '{K_LDA, M_IMM, 3'd2};  8'hA5: d = '{K_LDA, M_ZP, 3'd3};
            8'hB5: d = '{K_LDA, M_ZPX, 3'd4};  8'hAD: d = '{K_LDA, M_ABS, 3'd4};
            8'hBD: d = '{K_LDA, M_ABX, 3'd4};  8'hB9: d = '{K_LDA, M_ABY, 3'd4};
            8'hA1: d = '{K_LDA, M_IZX, 3'd6};  8'hB1: d = '{K_LDA, M_IZY, 3'd5};
            8'hA2: d = '{K_LDX, M_IMM, 3'd2};  8'hA6: d = '{K_LDX, M_ZP, 3'd3};
            8'hB6: d = '{K_LDX, M_ZPY, 3'd4};  8'hAE: d = '{K_LDX, M_ABS, 3'd4};
            8'hBE: d = '{K_LDX, M_ABY, 3'd4};
            8'hA0: d = '{K_LDY, M_IMM, 3'd2};  8'hA4: d = '{K_LDY, M_ZP, 3'd3};
            8'hB4: d = '{K_LDY, M_ZPX, 3'd4};  8'hAC: d = '{K_LDY, M_ABS, 3'd4};
            8'hBC: d = '{K_LDY, M_ABX, 3'd4};
            8'h85: d = '{K_STA, M_ZP, 3'd3};   8'h95: d = '{K_STA, M_ZPX, 3'd4};
            8'h8D: d = '{K_STA, M_ABS, 3'd4};  8'h9D: d = '{K_STA, M_ABX, 3'd5};
            8'h99: d = '{K_STA, M_ABY, 3'd5};  8'h81: d = '{K_STA, M_IZX, 3'd6};
            8'h91: d = '{K_STA, M_IZY, 3'd6};
            8'h86: d = '{K_STX, M_ZP, 3'd3};   8'h96: d = '{K_STX, M_ZPY, 3'd4};
            8'h8E: d = '{K_STX, M_ABS, 3'd4};
            8'h84: d = '{K_STY, M_ZP, 3'd3};   8'h94: d = '{K_STY, M_ZPX, 3'd4};
            8'h8C: d = '{K_STY, M_ABS, 3'd4};
            8'hAA: d = '{K_TAX, M_IMP, 3'd2};  8'hA8: d = '{K_TAY, M_IMP, 3'd2};
            8'h8A: d = '{K_TXA, M_IMP, 3'd2};  8'h98: d = '{K_TYA, M_IMP, 3'd2};
            8'hBA: d = '{K_TSX, M_IMP, 3'd2};  8'h9A: d = '{K_TXS, M_IMP, 3'd2};
            8'h48: d = '{K_PHA, M_IMP, 3'd3};  8'h08: d = '{K_PHP, M_IMP, 3'd3};
            8'h68: d = '{K_PLA, M_IMP, 3'd4};  8'h28: d = '{K_PLP, M_IMP, 3'd4};
            8'hE6: d = '{K_INC, M_ZP, 3'd5};   8'hF6: d = '{K_INC, M_ZPX, 3'd6};
            8'hEE: d = '{K_INC, M_ABS, 3'd6};  8'hFE: d = '{K_INC, M_ABX, 3'd7};
            8'hC6: d = '{K_DEC, M_ZP, 3'd5};   8'hD6: d = '{K_DEC, M_ZPX, 3'd6};
            8'hCE: d = '{K_DEC, M_ABS, 3'd6};  8'hDE: d = '{K_DEC, M_ABX, 3'd7};
            8'hE8: d = '{K_INX, M_IMP, 3'd2};  8'hC8: d = '{K_INY, M_IMP, 3'd2};
            8'hCA: d = '{K_DEX, M_IMP, 3'd2};  8'h88: d = '{K_DEY, M_IMP, 3'd2};
            8'h69: d = '{K_ADC, M_IMM, 3'd2};  8'h65: d = '{K_ADC, M_ZP, 3'd3};
            8'h75: d = '{K_ADC, M_ZPX, 3'd4};  8'h6D: d = '{K_ADC, M_ABS, 3'd4};
            8'h7D: d = '{K_ADC, M_ABX, 3'd4};  8'h79: d = '{K_ADC, M_ABY, 3'd4};
            8'h61: d = '{K_ADC, M_IZX, 3'd6};  8'h71: d = '{K_ADC, M_IZY, 3'd5};
            8'hE9: d = '{K_SBC, M_IMM, 3'd2};  8'hE5: d = '{K_SBC, M_ZP, 3'd3};
            8'hF5: d = '{K_SBC, M_ZPX, 3'd4};  8'hED: d = '{K_SBC, M_ABS, 3'd4};
            8'hFD: d = '{K_SBC, M_ABX, 3'd4};  8'hF9: d = '{K_SBC, M_ABY, 3'd4};
            8'hE1: d = '{K_SBC, M_IZX, 3'd6};  8'hF1: d = '{K_SBC, M_IZY, 3'd5};
            8'h29: d = '{K_AND, M_IMM, 3'd2};  8'h25: d = '{K_AND, M_ZP, 3'd3};
            8'h35: d = '{K_AND, M_ZPX, 3'd4};  8'h2D: d = '{K_AND, M_ABS, 3'd4};
            8'h3D: d = '{K_AND, M_ABX, 3'd4};  8'h39: d = '{K_AND, M_ABY, 3'd4};
            8'h21: d = '{K_AND, M_IZX, 3'd6};  8'h31: d = '{K_AND, M_IZY, 3'd5};
            8'h09: d = '{K_ORA, M_IMM, 3'd2};  8'h05: d = '{K_ORA, M_ZP, 3'd3};
            8'h15: d = '{K_ORA, M_ZPX, 3'd4};  8'h0D: d = '{K_ORA, M_ABS, 3'd4};
            8'h1D: d = '{K_ORA, M_ABX, 3'd4};  8'h19: d = '{K_ORA, M_ABY, 3'd4};
            8'h01: d = '{K_ORA, M_IZX, 3'd6};  8'h11: d = '{K_ORA, M_IZY, 3'd5};
            8'h49: d = '{K_EOR, M_IMM, 3'd2};  8'h45: d = '{K_EOR, M_ZP, 3'd3};
            8'h55: d = '{K_EOR, M_ZPX, 3'd4};  8'h4D: d = '{K_EOR, M_ABS, 3'd4};
            8'h5D: d = '{K_EOR, M_ABX, 3'd4};  8'h59: d = '{K_EOR, M_ABY, 3'd4};
            8'h41: d = '{K_EOR, M_IZX, 3'd6};  8'h51: d = '{K_EOR, M_IZY, 3'd5};
            8'h24: d = '{K_BIT, M_ZP, 3'd3};   8'h2C: d = '{K_BIT, M_ABS, 3'd4};
            8'h0A: d = '{K_ASLA, M_IMP, 3'd2}; 8'h06: d = '{K_ASL, M_ZP, 3'd5};
            8'h16: d = '{K_ASL, M_ZPX, 3'd6};  8'h0E: d = '{K_ASL, M_ABS, 3'd6};
            8'h1E: d = '{K_ASL, M_ABX, 3'd7};
            8'h4A: d = '{K_LSRA, M_IMP, 3'd2}; 8'h46: d = '{K_LSR, M_ZP, 3'd5};
            8'h56: d = '{K_LSR, M_ZPX, 3'd6};  8'h4E: d = '{K_LSR, M_ABS, 3'd6};
            8'h5E: d = '{K_LSR, M_ABX, 3'd7};
            8'h2A: d = '{K_ROLA, M_IMP, 3'd2}; 8'h26: d = '{K_ROL, M_ZP, 3'd5};
            8'h36: d = '{K_ROL, M_ZPX, 3'd6};  8'h2E: d = '{K_ROL, M_ABS, 3'd6};
            8'h3E: d = '{K_ROL, M_ABX, 3'd7};
            8'h6A: d = '{K_RORA, M_IMP, 3'd2}; 8'h66: d = '{K_ROR, M_ZP, 3'd5};
            8'h76: d = '{K_ROR, M_ZPX, 3'd6};  8'h6E: d = '{K_ROR, M_ABS, 3'd6};
            8'h7E: d = '{K_ROR, M_ABX, 3'd7};
            8'h18: d = '{K_CLC, M_IMP, 3'd2};  8'h38: d = '{K_SEC, M_IMP, 3'd2};
            8'h58: d = '{K_CLI, M_IMP, 3'd2};  8'h78: d = '{K_SEI, M_IMP, 3'd2};
            8'hB8: d = '{K_CLV, M_IMP, 3'd2};  8'hD8: d = '{K_CLD, M_IMP, 3'd2};
            8'hF8: d = '{K_SED, M_IMP, 3'd2};
            8'hC9: d = '{K_CMP, M_IMM, 3'd2};  8'hC5: d = '{K_CMP, M_ZP, 3'd3};
            8'hD5: d = '{K_CMP, M_ZPX, 3'd4};  8'hCD: d = '{K_CMP, M_ABS, 3'd4};
            8'hDD: d = '{K_CMP, M_ABX, 3'd4};  8'hD9: d = '{K_CMP, M_ABY, 3'd4};
            8'hC1: d = '{K_CMP, M_IZX, 3'd6};  8'hD1: d = '{K_CMP, M_IZY, 3'd5};
            8'hE0: d = '{K_CPX, M_IMM, 3'd2};  8'hE4: d = '{K_CPX, M_ZP, 3'd3};
            8'hEC: d = '{K_CPX, M_ABS, 3'd4};
            8'hC0: d = '{K_CPY, M_IMM, 3'd2};  8'hC4: d = '{K_CPY, M_ZP, 3'd3};
            8'hCC: d = '{K_CPY, M_ABS, 3'd4};
            8'h90: d = '{K_BCC, M_REL, 3'd2};  8'hB0: d = '{K_BCS, M_REL, 3'd2};
            8'hF0: d = '{K_BEQ, M_REL, 3'd2};  8'h30: d = '{K_BMI, M_REL, 3'd2};
            8'hD0: d = '{K_BNE, M_REL, 3'd2};  8'h10: d = '{K_BPL, M_REL, 3'd2};
            8'h50: d = '{K_BVC, M_REL, 3'd2};  8'h70: d = '{K_BVS, M_REL, 3'd2};
            8'h4C: d = '{K_JMP, M_ABS, 3'd3};  8'h6C: d = '{K_JMP, M_IND, 3'd5};
            8'h20: d = '{K_JSR, M_ABS, 3'd6};  8'h60: d = '{K_RTS, M_IMP, 3'd6};
            8'h40: d = '{K_RTI, M_IMP, 3'd6};  8'hEA: d = '{K_NOP, M_IMP, 3'd2};
            8'h00: d = '{K_BRK, M_IMP, 3'd7};
            default: d = '{K_NONE, M_IMP, 3'd0};
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/cis_ctrl.sv -----
// Sequencer state machine of the instruction step core.
`timescale 1ns / 1ps
module cis_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic [2:0]     i_op,
    input  cis_pkg::t_stat i_stat,
    output logic           busy,
    output logic           o_done,
    output cis_pkg::t_cmd  o_cmd
);
    import cis_pkg::*;

    t_state r_state, n_state;
    logic   r_brk, r_rst;
    logic   goto_op;

    // Skip the operand read for stores and jumps
    always_comb begin
        case (i_stat.kind) inside
            K_STA, K_STX, K_STY, K_JMP, K_JSR: goto_op = 1'b0;
            default:                           goto_op = 1'b1;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_WRITE: n_state = S_MWR;
                        OP_READ:  n_state = S_MRD;
                        OP_EXEC:  n_state = i_stat.running ? S_FETCH : S_DONE;
                        OP_RESET: n_state = S_VRD;
                        OP_IRQ:   n_state = i_stat.flag_i ? S_DONE : S_INT0;
                        OP_NMI:   n_state = S_INT0;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_MWR:  n_state = S_DONE;
            S_MRD:  n_state = S_MRD2;
            S_MRD2: n_state = S_DONE;
            S_VRD:  n_state = S_VLO;
            S_VLO:  n_state = S_VPC;
            S_VPC:  n_state = S_DONE;
            S_INT0: n_state = S_INT1;
            S_INT1: n_state = S_INT2;
            S_INT2: n_state = S_VRD;
            S_FETCH: n_state = S_IR;
            S_IR:   n_state = S_ADDR;
            S_ADDR: begin
                if (i_stat.kind == K_NONE)      n_state = S_DONE;
                else if (i_stat.mode == M_IMP)  n_state = S_EXEC;
                else                            n_state = S_A1;
            end
            S_A1: begin
                case (i_stat.mode) inside
                    M_IMM, M_REL:               n_state = S_EXEC;
                    M_ABS, M_ABX, M_ABY, M_IND: n_state = S_A2;
                    M_IZX, M_IZY:               n_state = S_PTR0;
                    default:                    n_state = goto_op ? S_RDOP : S_EXEC;
                endcase
            end
            S_A2: begin
                if (i_stat.mode == M_IND) n_state = S_IND0;
                else                      n_state = goto_op ? S_RDOP : S_EXEC;
            end
            S_PTR0: n_state = S_PTR1;
            S_PTR1: n_state = S_PTR2;
            S_PTR2: n_state = goto_op ? S_RDOP : S_EXEC;
            S_IND0: n_state = S_IND1;
            S_IND1: n_state = S_IND2;
            S_IND2: n_state = S_EXEC;
            S_RDOP: n_state = S_OPND;
            S_OPND: n_state = S_EXEC;
            S_EXEC: begin
                case (i_stat.kind) inside
                    K_PLA, K_PLP: n_state = S_PULL1;
                    K_RTS, K_RTI: n_state = S_RR;
                    K_JSR:        n_state = S_JS2;
                    K_BRK:        n_state = S_INT0;
                    default:      n_state = S_DONE;
                endcase
            end
            S_PULL1: n_state = S_PULL2;
            S_PULL2: n_state = S_DONE;
            S_RR:   n_state = (i_stat.kind == K_RTI) ? S_RI2 : S_RT2;
            S_RI2:  n_state = S_RT2;
            S_RT2:  n_state = S_RT3;
            S_RT3:  n_state = S_DONE;
            S_JS2:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.brk = r_brk;
        o_cmd.uop = U_NOP;
        busy      = (r_state != S_IDLE);
        o_done    = (r_state == S_DONE);
        unique case (r_state)
            S_IDLE:  o_cmd.uop = start ? U_LATCH : U_NOP;
            S_MWR:   o_cmd.uop = U_MWR;
            S_MRD:   o_cmd.uop = U_MRD;
            S_MRD2:  o_cmd.uop = U_RD_LATCH;
            S_VRD:   o_cmd.uop = U_RDEA;
            S_VLO:   o_cmd.uop = U_VLO;
            S_VPC:   o_cmd.uop = r_rst ? U_RESET_PC : U_VEC_PC;
            S_INT0:  o_cmd.uop = U_PUSH_PCH;
            S_INT1:  o_cmd.uop = U_PUSH_PCL;
            S_INT2:  o_cmd.uop = U_PUSH_P;
            S_FETCH: o_cmd.uop = U_FETCH;
            S_IR:    o_cmd.uop = U_IR;
            S_ADDR:  o_cmd.uop = (i_stat.kind == K_NONE) ? U_HALT : U_ADDR;
            S_A1:    o_cmd.uop = U_A1;
            S_A2:    o_cmd.uop = U_A2;
            S_PTR0:  o_cmd.uop = U_RDEA;
            S_PTR1:  o_cmd.uop = U_TMP_ZPINC;
            S_PTR2:  o_cmd.uop = U_EA_PTR;
            S_IND0:  o_cmd.uop = U_RDEA;
            S_IND1:  o_cmd.uop = U_TMP_PGINC;
            S_IND2:  o_cmd.uop = U_EA_PTR;
            S_RDOP:  o_cmd.uop = U_RDEA;
            S_OPND:  o_cmd.uop = U_OPND;
            S_EXEC:  o_cmd.uop = U_EXEC;
            S_PULL1: o_cmd.uop = U_PULL_RD;
            S_PULL2: o_cmd.uop = U_PULL_LATCH;
            S_RR:    o_cmd.uop = U_RR;
            S_RI2:   o_cmd.uop = U_RI2;
            S_RT2:   o_cmd.uop = U_RT2;
            S_RT3:   o_cmd.uop = U_RT3;
            S_JS2:   o_cmd.uop = U_JS2;
            S_DONE:  o_cmd.uop = U_NOP;
            default: o_cmd.uop = U_NOP;
        endcase
    end

    // Advance state; track break and reset sequences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_brk   <= 1'b0;
            r_rst   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && start) begin
                r_brk <= 1'b0;
                r_rst <= (i_op == OP_RESET);
            end else if (r_state == S_EXEC) begin
                r_brk <= (i_stat.kind == K_BRK);
            end
        end
    end

endmodule

// ----- rtl/cis_dp.sv -----
// Datapath of the instruction step core: registers, ALU and 64 KiB memory.
`timescale 1ns / 1ps
module cis_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cis_pkg::t_cmd  i_cmd,
    input  logic [2:0]     i_op,
    input  logic [15:0]    i_address,
    input  logic [7:0]     i_write_data,
    output cis_pkg::t_stat o_stat,
    output logic [15:0]    o_pc,
    output logic [7:0]     o_a,
    output logic [7:0]     o_x,
    output logic [7:0]     o_y,
    output logic [7:0]     o_sp,
    output logic [7:0]     o_p,
    output logic [7:0]     o_rd,
    output logic [2:0]     o_cyc,
    output logic           o_halted
);
    import cis_pkg::*;

    logic [7:0]  mem [0:65535];
    logic [7:0]  r_mdata;
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wd;

    logic [15:0] r_pc, n_pc, r_ea, n_ea, r_addr, n_addr;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_sp, n_sp, r_p, n_p;
    logic [7:0]  r_ir, n_ir, r_v, n_v, r_tmp, n_tmp, r_rd, n_rd, r_wdata, n_wdata;
    logic [2:0]  r_cyc, n_cyc;
    logic        r_run, n_run;

    t_dec        dec;
    logic [7:0]  val, addv, cmpreg, sh, b0x, b0y;
    logic [8:0]  sum9, cmpdiff;
    logic        shc, ovf, take;
    logic [15:0] jsr_ret, stack_addr, ptr, rel_ea;

    assign dec = cis_decode(r_ir);

    // Operand and ALU helpers
    always_comb begin
        val     = (dec.mode == M_IMP) ? r_a : r_v;
        addv    = (dec.kind == K_SBC) ? ~val : val;
        sum9    = {1'b0, r_a} + {1'b0, addv} + {8'h00, r_p[FL_C]};
        ovf     = (~(r_a[7] ^ addv[7])) & (r_a[7] ^ sum9[7]);
        case (dec.kind)
            K_CPX:   cmpreg = r_x;
            K_CPY:   cmpreg = r_y;
            default: cmpreg = r_a;
        endcase
        cmpdiff = {1'b0, cmpreg} - {1'b0, val};
        case (dec.kind) inside
            K_ASL, K_ASLA: begin sh = {val[6:0], 1'b0};       shc = val[7]; end
            K_LSR, K_LSRA: begin sh = {1'b0, val[7:1]};       shc = val[0]; end
            K_ROL, K_ROLA: begin sh = {val[6:0], r_p[FL_C]};  shc = val[7]; end
            default:       begin sh = {r_p[FL_C], val[7:1]};  shc = val[0]; end
        endcase
        case (dec.kind)
            K_BCC:   take = !r_p[FL_C];
            K_BCS:   take = r_p[FL_C];
            K_BEQ:   take = r_p[FL_Z];
            K_BMI:   take = r_p[FL_N];
            K_BNE:   take = !r_p[FL_Z];
            K_BPL:   take = !r_p[FL_N];
            K_BVC:   take = !r_p[FL_V];
            K_BVS:   take = r_p[FL_V];
            default: take = 1'b0;
        endcase
        jsr_ret    = r_pc - 16'd1;
        stack_addr = {STACK_PAGE, r_sp};
        ptr        = {r_mdata, r_tmp};
        rel_ea     = r_pc + {{8{r_mdata[7]}}, r_mdata};
        b0x        = r_mdata + r_x;
        b0y        = r_mdata + r_y;
    end

    // Decode the micro-operation into next values and the memory access
    always_comb begin
        logic [7:0] res;
        logic       zn_en;
        res      = 8'h00;
        zn_en    = 1'b0;
        n_pc = r_pc; n_ea = r_ea; n_addr = r_addr; n_a = r_a; n_x = r_x;
        n_y = r_y; n_sp = r_sp; n_p = r_p; n_ir = r_ir; n_v = r_v;
        n_tmp = r_tmp; n_rd = r_rd; n_wdata = r_wdata; n_cyc = r_cyc; n_run = r_run;
        mem_we   = 1'b0;
        mem_addr = r_pc;
        mem_wd   = r_a;
        unique case (i_cmd.uop)
            U_NOP: ;
            U_LATCH: begin
                n_addr  = i_address;
                n_wdata = i_write_data;
                n_rd    = 8'h00;
                n_cyc   = 3'd0;
                case (i_op)
                    OP_IRQ:  n_ea = VEC_IRQ;
                    OP_NMI:  n_ea = VEC_NMI;
                    default: n_ea = VEC_RST;
                endcase
            end
            U_MWR: begin
                mem_we = 1'b1; mem_addr = r_addr; mem_wd = r_wdata;
            end
            U_MRD:      mem_addr = r_addr;
            U_RD_LATCH: n_rd = r_mdata;
            U_RDEA:     mem_addr = r_ea;
            U_VLO: begin
                n_tmp = r_mdata; mem_addr = r_ea + 16'd1;
            end
            U_VEC_PC:   n_pc = ptr;
            U_RESET_PC: begin
                n_pc = ptr; n_run = 1'b1;
            end
            U_PUSH_PCH: begin
                mem_we = 1'b1; mem_addr = stack_addr; mem_wd = r_pc[15:8];
                n_sp = r_sp - 8'd1;
            end
            U_PUSH_PCL: begin
                mem_we = 1'b1; mem_addr = stack_addr; mem_wd = r_pc[7:0];
                n_sp = r_sp - 8'd1;
            end
            U_PUSH_P: begin
                mem_we = 1'b1; mem_addr = stack_addr;
                mem_wd = {r_p[7:6], 1'b1, i_cmd.brk, r_p[3:0]};
                n_sp = r_sp - 8'd1;
                n_p[FL_I] = 1'b1;
            end
            U_FETCH: begin
                mem_addr = r_pc; n_pc = r_pc + 16'd1;
            end
            U_IR:   n_ir = r_mdata;
            U_HALT: n_run = 1'b0;
            U_ADDR: begin
                n_cyc = dec.cyc;
                if (dec.mode != M_IMP) begin
                    mem_addr = r_pc; n_pc = r_pc + 16'd1;
                end
            end
            U_A1: begin
                case (dec.mode)
                    M_IMM: n_v  = r_mdata;
                    M_ZP:  n_ea = {8'h00, r_mdata};
                    M_ZPX: n_ea = {8'h00, b0x};
                    M_ZPY: n_ea = {8'h00, b0y};
                    M_REL: n_ea = rel_ea;
                    M_IZX: n_ea = {8'h00, b0x};
                    M_IZY: n_ea = {8'h00, r_mdata};
                    default: begin
                        n_tmp = r_mdata; mem_addr = r_pc; n_pc = r_pc + 16'd1;
                    end
                endcase
            end
            U_A2: begin
                case (dec.mode)
                    M_ABX:   n_ea = ptr + {8'h00, r_x};
                    M_ABY:   n_ea = ptr + {8'h00, r_y};
                    default: n_ea = ptr;
                endcase
            end
            U_TMP_ZPINC: begin
                n_tmp = r_mdata; mem_addr = {8'h00, r_ea[7:0] + 8'd1};
            end
            U_TMP_PGINC: begin
                n_tmp = r_mdata; mem_addr = {r_ea[15:8], r_ea[7:0] + 8'd1};
            end
            U_EA_PTR: n_ea = ptr + ((dec.mode == M_IZY) ? {8'h00, r_y} : 16'h0000);
            U_OPND:   n_v = r_mdata;
            U_EXEC: begin
                unique case (dec.kind)
                    K_LDA: begin n_a = val; res = val; zn_en = 1'b1; end
                    K_LDX: begin n_x = val; res = val; zn_en = 1'b1; end
                    K_LDY: begin n_y = val; res = val; zn_en = 1'b1; end
                    K_STA: begin mem_we = 1'b1; mem_addr = r_ea; mem_wd = r_a; end
                    K_STX: begin mem_we = 1'b1; mem_addr = r_ea; mem_wd = r_x; end
                    K_STY: begin mem_we = 1'b1; mem_addr = r_ea; mem_wd = r_y; end
                    K_TAX: begin n_x = r_a; res = r_a; zn_en = 1'b1; end
                    K_TAY: begin n_y = r_a; res = r_a; zn_en = 1'b1; end
                    K_TSX: begin n_x = r_sp; res = r_sp; zn_en = 1'b1; end
                    K_TXA: begin n_a = r_x; res = r_x; zn_en = 1'b1; end
                    K_TXS: n_sp = r_x;
                    K_TYA: begin n_a = r_y; res = r_y; zn_en = 1'b1; end
                    K_PHA: begin
                        mem_we = 1'b1; mem_addr = stack_addr; mem_wd = r_a;
                        n_sp = r_sp - 8'd1;
                    end
                    K_PHP: begin
                        mem_we = 1'b1; mem_addr = stack_addr; mem_wd = r_p | 8'h30;
                        n_sp = r_sp - 8'd1;
                    end
                    K_PLA, K_PLP, K_RTS, K_RTI: n_sp = r_sp + 8'd1;
                    K_DEC: begin
                        res = val - 8'd1; zn_en = 1'b1;
                        mem_we = 1'b1; mem_addr = r_ea; mem_wd = res;
                    end
                    K_INC: begin
                        res = val + 8'd1; zn_en = 1'b1;
                        mem_we = 1'b1; mem_addr = r_ea; mem_wd = res;
                    end
                    K_DEX: begin res = r_x - 8'd1; n_x = res; zn_en = 1'b1; end
                    K_DEY: begin res = r_y - 8'd1; n_y = res; zn_en = 1'b1; end
                    K_INX: begin res = r_x + 8'd1; n_x = res; zn_en = 1'b1; end
                    K_INY: begin res = r_y + 8'd1; n_y = res; zn_en = 1'b1; end
                    K_ADC, K_SBC: begin
                        res = sum9[7:0]; n_a = res; zn_en = 1'b1;
                        n_p[FL_C] = sum9[8]; n_p[FL_V] = ovf;
                    end
                    K_AND: begin res = r_a & val; n_a = res; zn_en = 1'b1; end
                    K_EOR: begin res = r_a ^ val; n_a = res; zn_en = 1'b1; end
                    K_ORA: begin res = r_a | val; n_a = res; zn_en = 1'b1; end
                    K_ASL, K_LSR, K_ROL, K_ROR: begin
                        res = sh; zn_en = 1'b1; n_p[FL_C] = shc;
                        mem_we = 1'b1; mem_addr = r_ea; mem_wd = sh;
                    end
                    K_ASLA, K_LSRA, K_ROLA, K_RORA: begin
                        res = sh; n_a = sh; zn_en = 1'b1; n_p[FL_C] = shc;
                    end
                    K_CLC: n_p[FL_C] = 1'b0;
                    K_CLD: n_p[FL_D] = 1'b0;
                    K_CLI: n_p[FL_I] = 1'b0;
                    K_CLV: n_p[FL_V] = 1'b0;
                    K_SEC: n_p[FL_C] = 1'b1;
                    K_SED: n_p[FL_D] = 1'b1;
                    K_SEI: n_p[FL_I] = 1'b1;
                    K_CMP, K_CPX, K_CPY: begin
                        n_p[FL_C] = !cmpdiff[8];
                        n_p[FL_Z] = (cmpreg == val);
                        n_p[FL_N] = cmpdiff[7];
                    end
                    K_BIT: begin
                        n_p[FL_Z] = ((r_a & val) == 8'h00);
                        n_p[FL_N] = val[7];
                        n_p[FL_V] = val[6];
                    end
                    K_BCC, K_BCS, K_BEQ, K_BMI, K_BNE, K_BPL, K_BVC, K_BVS: begin
                        if (take) n_pc = r_ea;
                    end
                    K_JMP: n_pc = r_ea;
                    K_JSR: begin
                        mem_we = 1'b1; mem_addr = stack_addr; mem_wd = jsr_ret[15:8];
                        n_sp = r_sp - 8'd1;
                    end
                    K_BRK: begin
                        n_pc = r_pc + 16'd1; n_ea = VEC_IRQ;
                    end
                    default: ;
                endcase
                if (zn_en) begin
                    n_p[FL_Z] = (res == 8'h00);
                    n_p[FL_N] = res[7];
                end
            end
            U_PULL_RD: mem_addr = stack_addr;
            U_PULL_LATCH: begin
                if (dec.kind == K_PLA) begin
                    n_a = r_mdata;
                    n_p[FL_Z] = (r_mdata == 8'h00);
                    n_p[FL_N] = r_mdata[7];
                end else begin
                    n_p = r_mdata | 8'h20;
                end
            end
            U_RR: begin
                mem_addr = stack_addr; n_sp = r_sp + 8'd1;
            end
            U_RI2: begin
                n_p = r_mdata | 8'h20; mem_addr = stack_addr; n_sp = r_sp + 8'd1;
            end
            U_RT2: begin
                n_tmp = r_mdata; mem_addr = stack_addr;
            end
            U_RT3: n_pc = ptr + ((dec.kind == K_RTS) ? 16'd1 : 16'd0);
            U_JS2: begin
                mem_we = 1'b1; mem_addr = stack_addr; mem_wd = jsr_ret[7:0];
                n_sp = r_sp - 8'd1; n_pc = r_ea;
            end
            default: ;
        endcase
    end

    // Memory: one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        r_mdata <= mem[mem_addr];
    end

    // Architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= 16'h0000;
            r_a   <= 8'h00;
            r_x   <= 8'h00;
            r_y   <= 8'h00;
            r_sp  <= SP_RESET;
            r_p   <= 8'h00;
            r_run <= 1'b1;
            r_rd  <= 8'h00;
            r_cyc <= 3'd0;
        end else begin
            r_pc  <= n_pc;
            r_a   <= n_a;
            r_x   <= n_x;
            r_y   <= n_y;
            r_sp  <= n_sp;
            r_p   <= n_p;
            r_run <= n_run;
            r_rd  <= n_rd;
            r_cyc <= n_cyc;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_ea    <= n_ea;
        r_addr  <= n_addr;
        r_ir    <= n_ir;
        r_v     <= n_v;
        r_tmp   <= n_tmp;
        r_wdata <= n_wdata;
    end

    assign o_stat   = '{dec.kind, dec.mode, r_p[FL_I], r_run};
    assign o_pc     = r_pc;
    assign o_a      = r_a;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_sp     = r_sp;
    assign o_p      = r_p;
    assign o_rd     = r_rd;
    assign o_cyc    = r_cyc;
    assign o_halted = !r_run;

endmodule

// ----- rtl/cpu_instruction_step_core.sv -----
// Top level of the instruction step core: sequencer plus datapath.
//
//  channel  | handshake           | words
//  ---------+---------------------+---------------------------------------
//  command  | start / busy        | i_op, i_address, i_write_data
//  result   | o_done (one cycle)  | registers, flags, read data, cycles, halt
//
// A command is taken when start is high and busy low; busy stays high through
// the result cycle, one command at a time. Memory is a single-port 64 KiB array
// with registered read. Synchronous active-low reset clears PC, A, X, Y, the
// flags, read data and cycles, sets the stack pointer to FD and clears halt;
// working registers and memory hold no reset.
// The receiver cannot stall: o_done marks the result for exactly one cycle.
`timescale 1ns / 1ps
`include "cpu_instruction_step_core_assert.svh"
module cpu_instruction_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_done,
    output logic [15:0] o_program_counter_out,
    output logic [7:0]  o_accumulator_out,
    output logic [7:0]  o_index_x_out,
    output logic [7:0]  o_index_y_out,
    output logic [7:0]  o_stack_pointer_out,
    output logic [7:0]  o_flags_out,
    output logic [7:0]  o_read_data,
    output logic [2:0]  o_cycles_used,
    output logic        o_halted
);
    import cis_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    cis_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_stat       (stat),
        .o_pc         (o_program_counter_out),
        .o_a          (o_accumulator_out),
        .o_x          (o_index_x_out),
        .o_y          (o_index_y_out),
        .o_sp         (o_stack_pointer_out),
        .o_p          (o_flags_out),
        .o_rd         (o_read_data),
        .o_cyc        (o_cycles_used),
        .o_halted     (o_halted)
    );

    // Checks
    `CIS_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "done held")
    `CIS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "no busy")
    `CIS_ASSERT_SAME(a_halt_on_done, i_clk, i_rst_n, $rose(o_halted), o_done,
                     "halt outside result")
    `CIS_ASSERT_SAME(a_cyc_running, i_clk, i_rst_n, o_done && (o_cycles_used != 3'd0),
                     !o_halted, "cycles while halted")

endmodule

// ----- verif/cpu_instruction_step_core_tb.sv -----
// Self-checking testbench of the instruction step core with its own CPU predictor.
`timescale 1ns / 1ps
module cpu_instruction_step_core_tb;
    import cis_pkg::*;

    // Item codes with no defined action
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    // Opcodes used by the directed part
    localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
    localparam logic [7:0] OPC_ADC_IMM = 8'h69;
    localparam logic [7:0] OPC_SBC_IMM = 8'hE9;
    localparam logic [7:0] OPC_JMP_IND = 8'h6C;
    localparam logic [7:0] OPC_BRK     = 8'h00;
    localparam logic [7:0] OPC_RTI     = 8'h40;
    localparam logic [7:0] OPC_SEI     = 8'h78;
    localparam logic [7:0] OPC_CLI     = 8'h58;
    localparam logic [7:0] OPC_BAD     = 8'h02;

    typedef struct packed {
        t_kind      kind;
        t_mode      mode;
        logic [2:0] cyc;
    } op_info_t;

    typedef struct {
        logic [15:0] pc;
        logic [7:0]  a, x, y, sp, p, rd;
        logic [2:0]  cyc;
        logic        halt;
    } cpu_view_t;

    // Opcode table: kind, addressing mode and base cycles
    function automatic op_info_t opcode_info(input logic [7:0] opc);
        case (opc)
            8'hA9: return '{K_LDA, M_IMM, 3'd2}; 8'hA5: return '{K_LDA, M_ZP, 3'd3};
            8'hB5: return '{K_LDA, M_ZPX, 3'd4}; 8'hAD: return '{K_LDA, M_ABS, 3'd4};
            8'hBD: return '{K_LDA, M_ABX, 3'd4}; 8'hB9: return '{K_LDA, M_ABY, 3'd4};
            8'hA1: return '{K_LDA, M_IZX, 3'd6}; 8'hB1: return '{K_LDA, M_IZY, 3'd5};
            8'hA2: return '{K_LDX, M_IMM, 3'd2}; 8'hA6: return '{K_LDX, M_ZP, 3'd3};
            8'hB6: return '{K_LDX, M_ZPY, 3'd4}; 8'hAE: return '{K_LDX, M_ABS, 3'd4};
            8'hBE: return '{K_LDX, M_ABY, 3'd4};
            8'hA0: return '{K_LDY, M_IMM, 3'd2}; 8'hA4: return '{K_LDY, M_ZP, 3'd3};
            8'hB4: return '{K_LDY, M_ZPX, 3'd4}; 8'hAC: return '{K_LDY, M_ABS, 3'd4};
            8'hBC: return '{K_LDY, M_ABX, 3'd4};
            8'h85: return '{K_STA, M_ZP, 3'd3};  8'h95: return '{K_STA, M_ZPX, 3'd4};
            8'h8D: return '{K_STA, M_ABS, 3'd4}; 8'h9D: return '{K_STA, M_ABX, 3'd5};
            8'h99: return '{K_STA, M_ABY, 3'd5}; 8'h81: return '{K_STA, M_IZX, 3'd6};
            8'h91: return '{K_STA, M_IZY, 3'd6};
            8'h86: return '{K_STX, M_ZP, 3'd3};  8'h96: return '{K_STX, M_ZPY, 3'd4};
            8'h8E: return '{K_STX, M_ABS, 3'd4};
            8'h84: return '{K_STY, M_ZP, 3'd3};  8'h94: return '{K_STY, M_ZPX, 3'd4};
            8'h8C: return '{K_STY, M_ABS, 3'd4};
            8'hAA: return '{K_TAX, M_IMP, 3'd2}; 8'hA8: return '{K_TAY, M_IMP, 3'd2};
            8'h8A: return '{K_TXA, M_IMP, 3'd2}; 8'h98: return '{K_TYA, M_IMP, 3'd2};
            8'hBA: return '{K_TSX, M_IMP, 3'd2}; 8'h9A: return '{K_TXS, M_IMP, 3'd2};
            8'h48: return '{K_PHA, M_IMP, 3'd3}; 8'h08: return '{K_PHP, M_IMP, 3'd3};
            8'h68: return '{K_PLA, M_IMP, 3'd4}; 8'h28: return '{K_PLP, M_IMP, 3'd4};
            8'hE6: return '{K_INC, M_ZP, 3'd5};  8'hF6: return '{K_INC, M_ZPX, 3'd6};
            8'hEE: return '{K_INC, M_ABS, 3'd6}; 8'hFE: return '{K_INC, M_ABX, 3'd7};
            8'hC6: return '{K_DEC, M_ZP, 3'd5};  8'hD6: return '{K_DEC, M_ZPX, 3'd6};
            8'hCE: return '{K_DEC, M_ABS, 3'd6}; 8'hDE: return '{K_DEC, M_ABX, 3'd7};
            8'hE8: return '{K_INX, M_IMP, 3'd2}; 8'hC8: return '{K_INY, M_IMP, 3'd2};
            8'hCA: return '{K_DEX, M_IMP, 3'd2}; 8'h88: return '{K_DEY, M_IMP, 3'd2};
            8'h69: return '{K_ADC, M_IMM, 3'd2}; 8'h65: return '{K_ADC, M_ZP, 3'd3};
            8'h75: return '{K_ADC, M_ZPX, 3'd4}; 8'h6D: return '{K_ADC, M_ABS, 3'd4};
            8'h7D: return '{K_ADC, M_ABX, 3'd4}; 8'h79: return '{K_ADC, M_ABY, 3'd4};
            8'h61: return '{K_ADC, M_IZX, 3'd6}; 8'h71: return '{K_ADC, M_IZY, 3'd5};
            8'hE9: return '{K_SBC, M_IMM, 3'd2}; 8'hE5: return '{K_SBC, M_ZP, 3'd3};
            8'hF5: return '{K_SBC, M_ZPX, 3'd4}; 8'hED: return '{K_SBC, M_ABS, 3'd4};
            8'hFD: return '{K_SBC, M_ABX, 3'd4}; 8'hF9: return '{K_SBC, M_ABY, 3'd4};
            8'hE1: return '{K_SBC, M_IZX, 3'd6}; 8'hF1: return '{K_SBC, M_IZY, 3'd5};
            8'h29: return '{K_AND, M_IMM, 3'd2}; 8'h25: return '{K_AND, M_ZP, 3'd3};
            8'h35: return '{K_AND, M_ZPX, 3'd4}; 8'h2D: return '{K_AND, M_ABS, 3'd4};
            8'h3D: return '{K_AND, M_ABX, 3'd4}; 8'h39: return '{K_AND, M_ABY, 3'd4};
            8'h21: return '{K_AND, M_IZX, 3'd6}; 8'h31: return '{K_AND, M_IZY, 3'd5};
            8'h09: return '{K_ORA, M_IMM, 3'd2}; 8'h05: return '{K_ORA, M_ZP, 3'd3};
            8'h15: return '{K_ORA, M_ZPX, 3'd4}; 8'h0D: return '{K_ORA, M_ABS, 3'd4};
            8'h1D: return '{K_ORA, M_ABX, 3'd4}; 8'h19: return '{K_ORA, M_ABY, 3'd4};
            8'h01: return '{K_ORA, M_IZX, 3'd6}; 8'h11: return '{K_ORA, M_IZY, 3'd5};
            8'h49: return '{K_EOR, M_IMM, 3'd2}; 8'h45: return '{K_EOR, M_ZP, 3'd3};
            8'h55: return '{K_EOR, M_ZPX, 3'd4}; 8'h4D: return '{K_EOR, M_ABS, 3'd4};
            8'h5D: return '{K_EOR, M_ABX, 3'd4}; 8'h59: return '{K_EOR, M_ABY, 3'd4};
            8'h41: return '{K_EOR, M_IZX, 3'd6}; 8'h51: return '{K_EOR, M_IZY, 3'd5};
            8'h24: return '{K_BIT, M_ZP, 3'd3};  8'h2C: return '{K_BIT, M_ABS, 3'd4};
            8'h0A: return '{K_ASLA, M_IMP, 3'd2}; 8'h06: return '{K_ASL, M_ZP, 3'd5};
            8'h16: return '{K_ASL, M_ZPX, 3'd6}; 8'h0E: return '{K_ASL, M_ABS, 3'd6};
            8'h1E: return '{K_ASL, M_ABX, 3'd7};
            8'h4A: return '{K_LSRA, M_IMP, 3'd2}; 8'h46: return '{K_LSR, M_ZP, 3'd5};
            8'h56: return '{K_LSR, M_ZPX, 3'd6}; 8'h4E: return '{K_LSR, M_ABS, 3'd6};
            8'h5E: return '{K_LSR, M_ABX, 3'd7};
            8'h2A: return '{K_ROLA, M_IMP, 3'd2}; 8'h26: return '{K_ROL, M_ZP, 3'd5};
            8'h36: return '{K_ROL, M_ZPX, 3'd6}; 8'h2E: return '{K_ROL, M_ABS, 3'd6};
            8'h3E: return '{K_ROL, M_ABX, 3'd7};
            8'h6A: return '{K_RORA, M_IMP, 3'd2}; 8'h66: return '{K_ROR, M_ZP, 3'd5};
            8'h76: return '{K_ROR, M_ZPX, 3'd6}; 8'h6E: return '{K_ROR, M_ABS, 3'd6};
            8'h7E: return '{K_ROR, M_ABX, 3'd7};
            8'h18: return '{K_CLC, M_IMP, 3'd2}; 8'h38: return '{K_SEC, M_IMP, 3'd2};
            8'h58: return '{K_CLI, M_IMP, 3'd2}; 8'h78: return '{K_SEI, M_IMP, 3'd2};
            8'hB8: return '{K_CLV, M_IMP, 3'd2}; 8'hD8: return '{K_CLD, M_IMP, 3'd2};
            8'hF8: return '{K_SED, M_IMP, 3'd2};
            8'hC9: return '{K_CMP, M_IMM, 3'd2}; 8'hC5: return '{K_CMP, M_ZP, 3'd3};
            8'hD5: return '{K_CMP, M_ZPX, 3'd4}; 8'hCD: return '{K_CMP, M_ABS, 3'd4};
            8'hDD: return '{K_CMP, M_ABX, 3'd4}; 8'hD9: return '{K_CMP, M_ABY, 3'd4};
            8'hC1: return '{K_CMP, M_IZX, 3'd6}; 8'hD1: return '{K_CMP, M_IZY, 3'd5};
            8'hE0: return '{K_CPX, M_IMM, 3'd2}; 8'hE4: return '{K_CPX, M_ZP, 3'd3};
            8'hEC: return '{K_CPX, M_ABS, 3'd4};
            8'hC0: return '{K_CPY, M_IMM, 3'd2}; 8'hC4: return '{K_CPY, M_ZP, 3'd3};
            8'hCC: return '{K_CPY, M_ABS, 3'd4};
            8'h90: return '{K_BCC, M_REL, 3'd2}; 8'hB0: return '{K_BCS, M_REL, 3'd2};
            8'hF0: return '{K_BEQ, M_REL, 3'd2}; 8'h30: return '{K_BMI, M_REL, 3'd2};
            8'hD0: return '{K_BNE, M_REL, 3'd2}; 8'h10: return '{K_BPL, M_REL, 3'd2};
            8'h50: return '{K_BVC, M_REL, 3'd2}; 8'h70: return '{K_BVS, M_REL, 3'd2};
            8'h4C: return '{K_JMP, M_ABS, 3'd3}; 8'h6C: return '{K_JMP, M_IND, 3'd5};
            8'h20: return '{K_JSR, M_ABS, 3'd6}; 8'h60: return '{K_RTS, M_IMP, 3'd6};
            8'h40: return '{K_RTI, M_IMP, 3'd6}; 8'hEA: return '{K_NOP, M_IMP, 3'd2};
            8'h00: return '{K_BRK, M_IMP, 3'd7};
            default: return '{K_NONE, M_IMP, 3'd0};
        endcase
    endfunction

    // Predicts the CPU and holds the register views still to come out
    class cpu_scoreboard;
        logic [7:0]  mem [0:65535];
        bit          written [0:65535];
        logic [7:0]  overlay [int];
        bit          dry;
        int          hole;
        logic [7:0]  a, x, y, sp, p;
        logic [15:0] pc;
        bit          run;
        cpu_view_t   pending[$];
        int          mismatches;

        function new();
            a = 8'd0; x = 8'd0; y = 8'd0; sp = SP_RESET; p = 8'd0; pc = 16'd0;
            run = 1'b1;
            dry = 1'b0;
            hole = -1;
            mismatches = 0;
        endfunction

        // Read a byte; a trial run notes the first byte never written
        function logic [7:0] rd(input logic [15:0] ad);
            if (dry && overlay.exists(int'(ad))) return overlay[int'(ad)];
            if (dry && !written[ad] && hole < 0) hole = int'(ad);
            return mem[ad];
        endfunction

        // Write a byte; a trial run keeps its writes aside
        function void wr(input logic [15:0] ad, input logic [7:0] v);
            if (dry) begin
                overlay[int'(ad)] = v;
            end else begin
                mem[ad] = v;
                written[ad] = 1'b1;
            end
        endfunction

        function logic [7:0] fetch();
            logic [7:0] v;
            v = rd(pc);
            pc = pc + 16'd1;
            return v;
        endfunction

        function logic [15:0] fetch_two();
            logic [7:0] lo;
            lo = fetch();
            return {fetch(), lo};
        endfunction

        function void push(input logic [7:0] v);
            wr({STACK_PAGE, sp}, v);
            sp = sp - 8'd1;
        endfunction

        function logic [7:0] pull();
            sp = sp + 8'd1;
            return rd({STACK_PAGE, sp});
        endfunction

        function void set_zn(input logic [7:0] v);
            p[FL_Z] = (v == 8'd0);
            p[FL_N] = v[7];
        endfunction

        function logic [15:0] vector(input logic [15:0] va);
            return {rd(va + 16'd1), rd(va)};
        endfunction

        function void take_interrupt(input logic [15:0] va, input logic [7:0] pushed);
            push(pc[15:8]);
            push(pc[7:0]);
            push(pushed);
            p[FL_I] = 1'b1;
            pc = vector(va);
        endfunction

        function logic [15:0] operand_addr(input t_mode m);
            logic [15:0] w;
            logic [7:0]  z, lo, hi;
            case (m)
                M_IMM: begin w = pc; pc = pc + 16'd1; return w; end
                M_ZP:  return {8'h00, fetch()};
                M_ZPX: begin z = fetch() + x; return {8'h00, z}; end
                M_ZPY: begin z = fetch() + y; return {8'h00, z}; end
                M_ABS: return fetch_two();
                M_ABX: return fetch_two() + {8'h00, x};
                M_ABY: return fetch_two() + {8'h00, y};
                M_IND: begin
                    // high byte stays in the pointer's page
                    w = fetch_two();
                    z = w[7:0] + 8'd1;
                    return {rd({w[15:8], z}), rd(w)};
                end
                M_IZX: begin
                    z = fetch() + x;
                    lo = rd({8'h00, z});
                    z = z + 8'd1;
                    return {rd({8'h00, z}), lo};
                end
                M_IZY: begin
                    z = fetch();
                    lo = rd({8'h00, z});
                    z = z + 8'd1;
                    hi = rd({8'h00, z});
                    return {hi, lo} + {8'h00, y};
                end
                M_REL: begin
                    z = fetch();
                    return pc + {{8{z[7]}}, z};
                end
                default: return 16'h0000;
            endcase
        endfunction

        function void compare(input logic [7:0] r, input logic [7:0] v);
            logic [7:0] d;
            d = r - v;
            p[FL_C] = (r >= v);
            p[FL_Z] = (r == v);
            p[FL_N] = d[7];
        endfunction

        function void add_with_carry(input logic [7:0] v);
            logic [8:0] s;
            s = {1'b0, a} + {1'b0, v} + {8'h00, p[FL_C]};
            p[FL_C] = s[8];
            p[FL_V] = (~(a[7] ^ v[7])) & (a[7] ^ s[7]);
            a = s[7:0];
            set_zn(a);
        endfunction

        function void put_shifted(input t_mode m, input logic [15:0] ea, input logic [7:0] r);
            if (m == M_IMP) a = r;
            else wr(ea, r);
            set_zn(r);
        endfunction

        // Execute one instruction, return its base cycles
        function logic [2:0] step_instruction();
            op_info_t    d;
            logic [15:0] ea, t;
            logic [7:0]  v, r, lo;
            logic        c, take;
            c = p[FL_C];
            take = 1'b0;
            ea = 16'h0000;
            d = opcode_info(fetch());
            if (d.kind == K_NONE) begin
                run = 0;
                return 3'd0;
            end
            if (d.mode == M_IMP) begin
                v = a;
            end else begin
                ea = operand_addr(d.mode);
                v = rd(ea);
            end
            case (d.kind)
                K_LDA: begin a = v; set_zn(v); end
                K_LDX: begin x = v; set_zn(v); end
                K_LDY: begin y = v; set_zn(v); end
                K_STA: wr(ea, a);
                K_STX: wr(ea, x);
                K_STY: wr(ea, y);
                K_TAX: begin x = a; set_zn(x); end
                K_TAY: begin y = a; set_zn(y); end
                K_TSX: begin x = sp; set_zn(x); end
                K_TXA: begin a = x; set_zn(a); end
                K_TXS: sp = x;
                K_TYA: begin a = y; set_zn(a); end
                K_PHA: push(a);
                K_PHP: push(p | 8'(1 << FL_B) | 8'(1 << FL_U));
                K_PLA: begin a = pull(); set_zn(a); end
                K_PLP: p = pull() | 8'(1 << FL_U);
                K_DEC: begin r = v - 8'd1; wr(ea, r); set_zn(r); end
                K_INC: begin r = v + 8'd1; wr(ea, r); set_zn(r); end
                K_DEX: begin x = x - 8'd1; set_zn(x); end
                K_DEY: begin y = y - 8'd1; set_zn(y); end
                K_INX: begin x = x + 8'd1; set_zn(x); end
                K_INY: begin y = y + 8'd1; set_zn(y); end
                K_ADC: add_with_carry(v);
                K_SBC: add_with_carry(~v);
                K_AND: begin a = a & v; set_zn(a); end
                K_EOR: begin a = a ^ v; set_zn(a); end
                K_ORA: begin a = a | v; set_zn(a); end
                K_ASL, K_ASLA: begin
                    p[FL_C] = v[7];
                    put_shifted(d.mode, ea, {v[6:0], 1'b0});
                end
                K_LSR, K_LSRA: begin
                    p[FL_C] = v[0];
                    put_shifted(d.mode, ea, {1'b0, v[7:1]});
                end
                K_ROL, K_ROLA: begin
                    p[FL_C] = v[7];
                    put_shifted(d.mode, ea, {v[6:0], c});
                end
                K_ROR, K_RORA: begin
                    p[FL_C] = v[0];
                    put_shifted(d.mode, ea, {c, v[7:1]});
                end
                K_CLC: p[FL_C] = 1'b0;
                K_CLD: p[FL_D] = 1'b0;
                K_CLI: p[FL_I] = 1'b0;
                K_CLV: p[FL_V] = 1'b0;
                K_SEC: p[FL_C] = 1'b1;
                K_SED: p[FL_D] = 1'b1;
                K_SEI: p[FL_I] = 1'b1;
                K_CMP: compare(a, v);
                K_CPX: compare(x, v);
                K_CPY: compare(y, v);
                K_BIT: begin
                    p[FL_Z] = ((a & v) == 8'd0);
                    p[FL_N] = v[7];
                    p[FL_V] = v[6];
                end
                K_BCC: take = !p[FL_C];
                K_BCS: take = p[FL_C];
                K_BEQ: take = p[FL_Z];
                K_BMI: take = p[FL_N];
                K_BNE: take = !p[FL_Z];
                K_BPL: take = !p[FL_N];
                K_BVC: take = !p[FL_V];
                K_BVS: take = p[FL_V];
                K_JMP: pc = ea;
                K_JSR: begin
                    t = pc - 16'd1;
                    push(t[15:8]);
                    push(t[7:0]);
                    pc = ea;
                end
                K_RTS: begin
                    lo = pull();
                    pc = {pull(), lo} + 16'd1;
                end
                K_RTI: begin
                    p = pull() | 8'(1 << FL_U);
                    lo = pull();
                    pc = {pull(), lo};
                end
                K_BRK: begin
                    pc = pc + 16'd1;
                    take_interrupt(VEC_IRQ, p | 8'(1 << FL_B) | 8'(1 << FL_U));
                end
                default: ;
            endcase
            if (take) pc = ea;
            return d.cyc;
        endfunction

        // Trial-run the next instruction; return the first unwritten byte it reads, or -1
        function int find_hole();
            logic [7:0]  save_a, save_x, save_y, save_sp, save_p;
            logic [15:0] save_pc;
            bit          save_run;
            if (!run) return -1;
            save_a = a; save_x = x; save_y = y; save_sp = sp; save_p = p;
            save_pc = pc; save_run = run;
            dry = 1'b1;
            overlay.delete();
            hole = -1;
            void'(step_instruction());
            a = save_a; x = save_x; y = save_y; sp = save_sp; p = save_p;
            pc = save_pc; run = save_run;
            dry = 1'b0;
            overlay.delete();
            return hole;
        endfunction

        // Note an accepted word and queue the register view it leaves
        function void note_word(input logic [2:0] op, input logic [15:0] adr,
                                input logic [7:0] wd);
            cpu_view_t  e;
            logic [7:0] int_p;
            e.rd = 8'd0;
            e.cyc = 3'd0;
            int_p = (p | 8'(1 << FL_U)) & ~8'(1 << FL_B);
            case (op)
                OP_WRITE: wr(adr, wd);
                OP_READ:  e.rd = rd(adr);
                OP_EXEC:  if (run) e.cyc = step_instruction();
                OP_RESET: begin pc = vector(VEC_RST); run = 1; end
                OP_IRQ:   if (!p[FL_I]) take_interrupt(VEC_IRQ, int_p);
                OP_NMI:   take_interrupt(VEC_NMI, int_p);
                default: ;
            endcase
            e.pc = pc; e.a = a; e.x = x; e.y = y; e.sp = sp; e.p = p;
            e.halt = !run;
            pending.push_back(e);
        endfunction

        task report(input string what, input logic [15:0] got, input logic [15:0] want);
            $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
            mismatches++;
        endtask

        // Check one result word against the oldest expectation
        task check_word(input cpu_view_t g);
            cpu_view_t e;
            if (pending.size() == 0) begin
                report("unexpected result", g.pc, 16'h0);
                return;
            end
            e = pending.pop_front();
            if (g.pc !== e.pc) report("pc", g.pc, e.pc);
            if (g.a !== e.a) report("a", g.a, e.a);
            if (g.x !== e.x) report("x", g.x, e.x);
            if (g.y !== e.y) report("y", g.y, e.y);
            if (g.sp !== e.sp) report("sp", g.sp, e.sp);
            if (g.p !== e.p) report("flags", g.p, e.p);
            if (g.rd !== e.rd) report("read data", g.rd, e.rd);
            if (g.cyc !== e.cyc) report("cycles", g.cyc, e.cyc);
            if (g.halt !== e.halt) report("halted", g.halt, e.halt);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_op;
    logic [15:0] i_address;
    logic [7:0]  i_write_data;
    logic        o_done;
    logic [15:0] o_program_counter_out;
    logic [7:0]  o_accumulator_out, o_index_x_out, o_index_y_out;
    logic [7:0]  o_stack_pointer_out, o_flags_out, o_read_data;
    logic [2:0]  o_cycles_used;
    logic        o_halted;

    cpu_scoreboard cpu_sb;
    bit            gaps_on;
    cpu_view_t     seen;

    cpu_instruction_step_core u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Capture each result word on its strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen.pc = o_program_counter_out; seen.a = o_accumulator_out;
            seen.x = o_index_x_out; seen.y = o_index_y_out;
            seen.sp = o_stack_pointer_out; seen.p = o_flags_out;
            seen.rd = o_read_data; seen.cyc = o_cycles_used; seen.halt = o_halted;
            cpu_sb.check_word(seen);
        end
    end

    // Drive one word and hold it until the core takes it
    task send_word(input logic [2:0] op, input logic [15:0] adr, input logic [7:0] wd);
        if (gaps_on && $urandom_range(99) < 25) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op <= op;
        i_address <= adr;
        i_write_data <= wd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cpu_sb.note_word(op, adr, wd);
    endtask

    // Read a byte back, writing it first when it was never written
    task read_item(input logic [15:0] adr);
        if (!cpu_sb.written[adr]) send_word(OP_WRITE, adr, 8'($urandom));
        send_word(OP_READ, adr, 8'($urandom));
    endtask

    // Place an instruction at the predicted PC, fill the bytes it reads, execute it
    task run_opcode(input logic [7:0] opc, input logic [7:0] b1, input logic [7:0] b2);
        logic [15:0] at;
        int          gap_at;
        at = cpu_sb.pc;
        send_word(OP_WRITE, at, opc);
        send_word(OP_WRITE, at + 16'd1, b1);
        send_word(OP_WRITE, at + 16'd2, b2);
        gap_at = cpu_sb.find_hole();
        while (gap_at >= 0) begin
            send_word(OP_WRITE, gap_at[15:0], 8'($urandom));
            gap_at = cpu_sb.find_hole();
        end
        send_word(OP_EXEC, 16'($urandom), 8'($urandom));
    endtask

    // Hold the sender until every expected word has come
    task drain();
        int n;
        n = 0;
        while (cpu_sb.pending.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    initial begin
        #2_000_000;
        $display("cpu_instruction_step_core regression: fail");
        $finish;
    end

    initial begin
        logic [7:0] opc;
        int         pick;
        cpu_sb = new();
        gaps_on = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_op <= OP_WRITE;
        i_address <= 16'h0000;
        i_write_data <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Vectors: reset to 0200, IRQ/BRK to 0300, NMI to 0400, each handler an RTI
        send_word(OP_WRITE, VEC_RST, 8'h00);
        send_word(OP_WRITE, VEC_RST + 16'd1, 8'h02);
        send_word(OP_WRITE, VEC_IRQ, 8'h00);
        send_word(OP_WRITE, VEC_IRQ + 16'd1, 8'h03);
        send_word(OP_WRITE, VEC_NMI, 8'h00);
        send_word(OP_WRITE, VEC_NMI + 16'd1, 8'h04);
        send_word(OP_WRITE, 16'h0300, OPC_RTI);
        send_word(OP_WRITE, 16'h0400, OPC_RTI);
        send_word(OP_WRITE, 16'h12FF, 8'h00);
        send_word(OP_WRITE, 16'h1200, 8'h05);
        send_word(OP_WRITE, 16'h1300, 8'hEE);
        send_word(OP_RESET, 16'hFFFF, 8'hFF);
        read_item(16'h0000);
        read_item(16'hFFFF);
        // Signed overflow on add, borrow on subtract
        run_opcode(OPC_LDA_IMM, 8'h7F, 8'h00);
        run_opcode(OPC_ADC_IMM, 8'h01, 8'h00);
        run_opcode(OPC_SBC_IMM, 8'hFF, 8'h00);
        // Indirect jump through a pointer at a page end wraps within the page
        run_opcode(OPC_JMP_IND, 8'hFF, 8'h12);
        run_opcode(OPC_BRK, 8'h00, 8'h00);
        send_word(OP_EXEC, 16'h0000, 8'h00);
        run_opcode(OPC_SEI, 8'h00, 8'h00);
        send_word(OP_IRQ, 16'h0000, 8'h00);
        run_opcode(OPC_CLI, 8'h00, 8'h00);
        send_word(OP_IRQ, 16'h0000, 8'h00);
        send_word(OP_EXEC, 16'h0000, 8'h00);
        send_word(OP_NMI, 16'h0000, 8'h00);
        send_word(OP_EXEC, 16'h0000, 8'h00);
        // Unknown opcode halts; execute and interrupts while halted
        run_opcode(OPC_BAD, 8'h00, 8'h00);
        send_word(OP_EXEC, 16'h0000, 8'h00);
        send_word(OP_NMI, 16'h0000, 8'h00);
        send_word(OP_IRQ, 16'h0000, 8'h00);
        send_word(OP_SPARE6, 16'hFFFF, 8'hFF);
        send_word(OP_SPARE7, 16'h0000, 8'h00);
        send_word(OP_RESET, 16'h0000, 8'h00);
        start <= 1'b0;
        drain();

        // Random programs: mostly known opcodes, with noise items mixed in
        for (int i = 0; i < 270; i++) begin
            gaps_on = (i < 100 || i >= 160);
            pick = $urandom_range(99);
            if (cpu_sb.run == 0 && pick < 40) begin
                send_word(OP_RESET, 16'($urandom), 8'($urandom));
            end else if (pick < 66) begin
                do opc = 8'($urandom); while (opcode_info(opc).kind == K_NONE);
                run_opcode(opc, 8'($urandom), 8'($urandom));
            end else if (pick < 70) begin
                do opc = 8'($urandom); while (opcode_info(opc).kind != K_NONE);
                run_opcode(opc, 8'($urandom), 8'($urandom));
            end else if (pick < 74) begin
                send_word(OP_RESET, 16'($urandom), 8'($urandom));
            end else if (pick < 80) begin
                send_word(OP_IRQ, 16'($urandom), 8'($urandom));
            end else if (pick < 83) begin
                send_word(OP_NMI, 16'($urandom), 8'($urandom));
            end else if (pick < 90) begin
                read_item(16'($urandom));
            end else if (pick < 96) begin
                send_word(OP_WRITE, 16'($urandom), 8'($urandom));
            end else if (pick < 98) begin
                send_word(OP_SPARE6, 16'($urandom), 8'($urandom));
            end else begin
                send_word(OP_SPARE7, 16'($urandom), 8'($urandom));
            end
        end
        start <= 1'b0;
        drain();
        repeat (30) @(posedge i_clk);

        if (cpu_sb.mismatches == 0 && cpu_sb.pending.size() == 0) begin
            $display("cpu_instruction_step_core regression: pass");
        end else begin
            $display("cpu_instruction_step_core regression: fail");
        end
        $finish;
    end
endmodule
